// ===== rtl/mtsc_pkg.sv =====
package mtsc_pkg;

    localparam int SAMPLE_W           = 12;
    localparam int WINDOW_DEF         = 16;
    localparam int SUPPLY_SAMPLES_DEF = 50;

    localparam int SUM_W         = 18;
    localparam int SCALE_W       = 20;
    localparam int RECIP_SHIFT   = 24;
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int SUPPLY_PROD_W = SUM_W + SCALE_W;
    localparam int MV_W          = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_CAL_SLOPE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_OFFSET   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LOW     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLT_SCALE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_SCALE = 3'd5;

    localparam logic signed [23:0] CAL_SLOPE_RST    = 24'sd0;
    localparam logic signed [23:0] CAL_OFFSET_RST   = 24'sd0;
    localparam logic signed [15:0] TEMP_LOW_RST     = -16'sd4000;
    localparam logic signed [15:0] TEMP_HIGH_RST    = 16'sd20000;
    localparam logic [SCALE_W-1:0] VOLT_SCALE_RST   = 20'd52800;
    localparam logic [SCALE_W-1:0] SUPPLY_SCALE_RST = 20'd286059;

    localparam logic [15:0] TEMP_INVALID = 16'hFFFF;
    localparam logic [MV_W-1:0] MV_MAX   = 16'hFFFF;

    typedef struct packed {
        logic                gt;
        logic [SAMPLE_W-1:0] val;
    } mtsc_link_t;

    typedef struct packed {
        logic                     done;
        logic [SUPPLY_PROD_W-1:0] prod;
    } mtsc_supply_t;

endpackage

// ===== rtl/median_temp_sensor_conditioner.sv =====
// Each accepted beat passes the a, b and c stage registers and the output register.
// Throughput: one beat per cycle; the insertion cell row takes one sample
// per cycle. Every stage advances only while the output register is free or
// being taken, so s_tready follows m_tready.
// Reset (rst_n, async): pipeline, window and supply counters cleared,
// registers back to defaults; window cell contents are not cleared.
module median_temp_sensor_conditioner #(
    parameter int WINDOW         = mtsc_pkg::WINDOW_DEF,
    parameter int SUPPLY_SAMPLES = mtsc_pkg::SUPPLY_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // temp_sample, supply_sample
    input  logic                                s_tuser,   // restart_supply
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // median_adc, sensor_mv, temperature_x100, supply_mv, zero pad
    output logic [63:0]                         m_tdata,
    output logic [2:0]                          m_tuser,   // window_done, temp_valid,
                                                           // supply_done
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mtsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int FW = $clog2(WINDOW);
    localparam int SP = mtsc_pkg::SUPPLY_PROD_W;

    logic signed [23:0]            cal_slope_reg;
    logic signed [23:0]            cal_offset_reg;
    logic signed [15:0]            temp_low_reg;
    logic signed [15:0]            temp_high_reg;
    logic [mtsc_pkg::SCALE_W-1:0]  volt_scale_reg;
    logic [mtsc_pkg::SCALE_W-1:0]  supply_scale_reg;

    logic          en;
    logic          accept;
    logic [11:0]   temp_sample;
    logic [11:0]   supply_sample;

    logic [FW-1:0] fill_reg;
    logic          wdone;
    logic [11:0]   med_next;

    logic          va_reg, vb_reg, vc_reg;
    logic          wdone_a_reg, wdone_b_reg, wdone_c_reg;
    logic [11:0]   med_a_reg, med_b_reg, med_c_reg;
    logic signed [36:0] tprod_b_reg;
    logic [31:0]   mvprod_b_reg;
    logic [15:0]   mv_c_reg;
    logic signed [40:0] t_c_reg;

    logic signed [36:0] slope_x, med_x;
    logic signed [40:0] off_x, lo_x, hi_x, whole;
    logic          in_range;
    logic [15:0]   temp_out;
    logic [15:0]   supply_mv;

    logic          m_tvalid_reg;
    logic [63:0]   m_tdata_reg;
    logic [2:0]    m_tuser_reg;

    mtsc_pkg::mtsc_supply_t supply_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_slope_reg    <= mtsc_pkg::CAL_SLOPE_RST;
            cal_offset_reg   <= mtsc_pkg::CAL_OFFSET_RST;
            temp_low_reg     <= mtsc_pkg::TEMP_LOW_RST;
            temp_high_reg    <= mtsc_pkg::TEMP_HIGH_RST;
            volt_scale_reg   <= mtsc_pkg::VOLT_SCALE_RST;
            supply_scale_reg <= mtsc_pkg::SUPPLY_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mtsc_pkg::REG_CAL_SLOPE:    cal_slope_reg    <= cfg_data;
                mtsc_pkg::REG_CAL_OFFSET:   cal_offset_reg   <= cfg_data;
                mtsc_pkg::REG_TEMP_LOW:     temp_low_reg     <= cfg_data[15:0];
                mtsc_pkg::REG_TEMP_HIGH:    temp_high_reg    <= cfg_data[15:0];
                mtsc_pkg::REG_VOLT_SCALE:   volt_scale_reg   <= cfg_data[19:0];
                mtsc_pkg::REG_SUPPLY_SCALE: supply_scale_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign en            = !m_tvalid_reg || m_tready;
    assign s_tready      = en;
    assign accept        = s_tvalid && en;
    assign temp_sample   = s_tdata[11:0];
    assign supply_sample = s_tdata[23:12];
    assign wdone         = (fill_reg == FW'(WINDOW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= wdone ? '0 : fill_reg + FW'(1);
            end
            if (en)
            begin
                va_reg       <= accept;
                vb_reg       <= va_reg;
                vc_reg       <= vb_reg;
                m_tvalid_reg <= vc_reg;
            end
        end
    end

    mtsc_sort_row #(
        .WINDOW (WINDOW)
    ) u_sort_row (
        .clk      (clk),
        .en       (accept),
        .x        (temp_sample),
        .fill     (fill_reg),
        .med_next (med_next)
    );

    mtsc_supply #(
        .SUPPLY_SAMPLES (SUPPLY_SAMPLES)
    ) u_supply (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .accept  (accept),
        .restart (s_tuser),
        .sample  (supply_sample),
        .scale   (supply_scale_reg),
        .res     (supply_res)
    );

    assign slope_x = 37'(cal_slope_reg);
    assign med_x   = 37'({1'b0, med_a_reg});
    assign off_x   = 41'(cal_offset_reg) <<< 16;
    assign lo_x    = 41'(temp_low_reg) <<< 16;
    assign hi_x    = 41'(temp_high_reg) <<< 16;

    always_comb
    begin
        in_range = (t_c_reg >= lo_x) && (t_c_reg <= hi_x);
        whole    = t_c_reg >>> 16;
        // round toward zero
        if (t_c_reg[40] && (t_c_reg[15:0] != '0))
        begin
            whole = whole + 41'sd1;
        end
        temp_out  = in_range ? whole[15:0] : mtsc_pkg::TEMP_INVALID;
        supply_mv = (supply_res.prod[SP-1:32] != '0) ? mtsc_pkg::MV_MAX
                                                     : supply_res.prod[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wdone_a_reg  <= accept && wdone;
            med_a_reg    <= med_next;

            wdone_b_reg  <= wdone_a_reg;
            med_b_reg    <= med_a_reg;
            tprod_b_reg  <= slope_x * med_x;
            mvprod_b_reg <= 32'(med_a_reg) * 32'(volt_scale_reg);

            wdone_c_reg  <= wdone_b_reg;
            med_c_reg    <= med_b_reg;
            mv_c_reg     <= mvprod_b_reg[31:16];
            t_c_reg      <= 41'(tprod_b_reg) + off_x;

            m_tdata_reg[11:0]  <= wdone_c_reg ? med_c_reg : '0;
            m_tdata_reg[27:12] <= wdone_c_reg ? mv_c_reg : '0;
            m_tdata_reg[43:28] <= wdone_c_reg ? temp_out : '0;
            m_tdata_reg[59:44] <= supply_res.done ? supply_mv : '0;
            m_tdata_reg[63:60] <= '0;
            m_tuser_reg[0]     <= wdone_c_reg;
            m_tuser_reg[1]     <= wdone_c_reg && in_range;
            m_tuser_reg[2]     <= supply_res.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW - 1))
        else $error("window fill count out of range");

    a_idle_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[43:0] == '0) && !m_tuser[1])
        else $error("window fields set without a completed window");

    a_invalid_temp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && !m_tuser[1] |->
            m_tdata[43:28] == mtsc_pkg::TEMP_INVALID)
        else $error("out-of-bounds temperature not flagged");

    a_idle_supply: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tdata[59:44] == '0)
        else $error("supply value set without a completed average");

endmodule

// ===== rtl/mtsc_cell.sv =====
module mtsc_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [mtsc_pkg::SAMPLE_W-1:0] x,
    input  logic                          occ,
    input  mtsc_pkg::mtsc_link_t          left,
    output mtsc_pkg::mtsc_link_t          right
);

    logic [mtsc_pkg::SAMPLE_W-1:0] val_reg;
    logic [mtsc_pkg::SAMPLE_W-1:0] val_next;

    // empty cell counts as +infinity
    assign right.gt  = !occ || (val_reg > x);
    assign right.val = val_reg;

    always_comb
    begin
        priority if (left.gt)
        begin
            val_next = left.val;
        end
        else if (right.gt)
        begin
            val_next = x;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
        end
    end

endmodule

// ===== rtl/mtsc_sort_row.sv =====
module mtsc_sort_row #(
    parameter int WINDOW = mtsc_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [mtsc_pkg::SAMPLE_W-1:0] x,
    input  logic [$clog2(WINDOW)-1:0]     fill,
    output logic [mtsc_pkg::SAMPLE_W-1:0] med_next
);

    localparam int FW  = $clog2(WINDOW);
    localparam int MED = WINDOW / 2;

    mtsc_pkg::mtsc_link_t link [WINDOW];

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        localparam logic [FW-1:0] IDX = FW'(i);
        mtsc_pkg::mtsc_link_t left_in;
        logic                 occ;

        assign occ = IDX < fill;

        if (i == 0)
        begin : g_head
            assign left_in = '0;
        end
        else
        begin : g_body
            assign left_in = link[i-1];
        end

        mtsc_cell u_cell (
            .clk   (clk),
            .en    (en),
            .x     (x),
            .occ   (occ),
            .left  (left_in),
            .right (link[i])
        );
    end

    always_comb
    begin
        priority if (link[MED-1].gt)
        begin
            med_next = link[MED-1].val;
        end
        else if (link[MED].gt)
        begin
            med_next = x;
        end
        else
        begin
            med_next = link[MED].val;
        end
    end

endmodule

// ===== rtl/mtsc_supply.sv =====
module mtsc_supply #(
    parameter int SUPPLY_SAMPLES = mtsc_pkg::SUPPLY_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          accept,
    input  logic                          restart,
    input  logic [mtsc_pkg::SAMPLE_W-1:0] sample,
    input  logic [mtsc_pkg::SCALE_W-1:0]  scale,
    output mtsc_pkg::mtsc_supply_t        res
);

    localparam int CW = $clog2(SUPPLY_SAMPLES + 1);
    localparam int SW = mtsc_pkg::SUM_W;
    localparam int RW = mtsc_pkg::RECIP_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(SUPPLY_SAMPLES);
    // ceil(2^24 / N): exact floor division for any 18-bit sum, N < 64
    localparam logic [RW-1:0] RECIP =
        RW'(((1 << mtsc_pkg::RECIP_SHIFT) + SUPPLY_SAMPLES - 1) / SUPPLY_SAMPLES);

    logic [CW-1:0] cnt_reg, cnt_next, cnt0;
    logic [SW-1:0] sum_reg, sum_next, sum0, sum1;
    logic          hit;

    logic [SW-1:0]    sum_a_reg;
    logic             done_a_reg;
    logic [SW+RW-1:0] quot_prod;
    logic [SW-1:0]    avg_b_reg;
    logic             done_b_reg;
    mtsc_pkg::mtsc_supply_t res_reg;

    always_comb
    begin
        cnt0     = restart ? '0 : cnt_reg;
        sum0     = restart ? '0 : sum_reg;
        sum1     = sum0 + SW'(sample);
        hit      = 1'b0;
        cnt_next = cnt0;
        sum_next = sum0;
        if (cnt0 < CNT_MAX)
        begin
            cnt_next = cnt0 + CW'(1);
            hit      = (cnt_next == CNT_MAX);
            sum_next = hit ? '0 : sum1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end

    assign quot_prod = (SW+RW)'(sum_a_reg) * (SW+RW)'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_a_reg    <= sum1;
            done_a_reg   <= accept && hit;
            avg_b_reg    <= quot_prod[mtsc_pkg::RECIP_SHIFT +: SW];
            done_b_reg   <= done_a_reg;
            res_reg.done <= done_b_reg;
            res_reg.prod <= mtsc_pkg::SUPPLY_PROD_W'(avg_b_reg)
                          * mtsc_pkg::SUPPLY_PROD_W'(scale);
        end
    end

    assign res = res_reg;

endmodule

// ===== test/mtsc_reading_check.sv =====
module mtsc_reading_check
    import mtsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [23:0]            s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [63:0]            m_tdata,
    input  logic [2:0]             m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     pending,
    output int                     errors,
    output int                     windows,
    output int                     rejected,
    output int                     averages
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN       = WINDOW_DEF;
    localparam int SUP_N     = SUPPLY_SAMPLES_DEF;
    localparam int PRINT_CAP = 40;

    typedef struct {
        logic        win_done;
        logic [11:0] median;
        logic [15:0] sensor_mv;
        logic [15:0] temp_x100;
        logic        temp_ok;
        logic        sup_done;
        logic [15:0] supply_mv;
    } reading_t;

    reading_t readings_due[$];

    logic signed [23:0] slope;
    logic signed [23:0] offset;
    logic signed [15:0] low_bound;
    logic signed [15:0] high_bound;
    logic [SCALE_W-1:0] volt_scale;
    logic [SCALE_W-1:0] supply_scale;

    logic [11:0] samples [WIN];
    int          fill;
    int          sup_count;
    int unsigned sup_sum;
    int          beat_no = 0;

    function automatic logic [11:0] window_median();
        logic [11:0] s [WIN];
        logic [11:0] x;
        int i;
        int j;
        s = samples;
        for (i = 1; i < WIN; i++)
        begin
            x = s[i];
            j = i;
            while (j > 0 && s[j-1] > x)
            begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = x;
        end
        return s[WIN/2];
    endfunction

    function automatic logic [15:0] scale_mv(input logic [11:0] count,
                                             input logic [SCALE_W-1:0] scale);
        longint unsigned p;
        p = (longint'(count) * longint'(scale)) >> 16;
        return (p > MV_MAX) ? MV_MAX : p[15:0];
    endfunction

    // one beat in, one reading out; updates window and supply state
    function automatic reading_t condition_sample(input logic [11:0] temp,
                                                  input logic [11:0] sup,
                                                  input logic restart);
        reading_t r;
        longint t;
        int unsigned avg;
        r = '{default: '0};
        if (fill >= WIN)
            fill = 0;
        samples[fill] = temp;
        fill++;
        if (fill >= WIN)
        begin
            fill = 0;
            r.win_done = 1'b1;
            r.median = window_median();
            r.sensor_mv = scale_mv(r.median, volt_scale);
            t = longint'(slope) * longint'(r.median) + longint'(offset) * 65536;
            if (t >= longint'(low_bound) * 65536 && t <= longint'(high_bound) * 65536)
            begin
                // signed divide truncates toward zero
                r.temp_x100 = 16'(t / 65536);
                r.temp_ok = 1'b1;
            end
            else
                r.temp_x100 = TEMP_INVALID;
        end
        if (restart)
        begin
            sup_count = 0;
            sup_sum = 0;
        end
        // once complete, samples are dropped until the next restart
        if (sup_count < SUP_N)
        begin
            sup_sum = (sup_sum + sup) % (1 << SUM_W);
            sup_count++;
            if (sup_count == SUP_N)
            begin
                avg = sup_sum / SUP_N;
                r.sup_done = 1'b1;
                r.supply_mv = scale_mv(12'(avg), supply_scale);
                sup_sum = 0;
            end
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] result beat %0d: %s got %0h, expected %0h",
                     $time, beat_no, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t want;
        if (!rst_n)
        begin
            slope        = CAL_SLOPE_RST;
            offset       = CAL_OFFSET_RST;
            low_bound    = TEMP_LOW_RST;
            high_bound   = TEMP_HIGH_RST;
            volt_scale   = VOLT_SCALE_RST;
            supply_scale = SUPPLY_SCALE_RST;
            fill         = 0;
            sup_count    = 0;
            sup_sum      = 0;
            readings_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_CAL_SLOPE:    slope        = cfg_data;
                    REG_CAL_OFFSET:   offset       = cfg_data;
                    REG_TEMP_LOW:     low_bound    = cfg_data[15:0];
                    REG_TEMP_HIGH:    high_bound   = cfg_data[15:0];
                    REG_VOLT_SCALE:   volt_scale   = cfg_data[SCALE_W-1:0];
                    REG_SUPPLY_SCALE: supply_scale = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            if (m_tvalid && m_tready)
            begin
                beat_no++;
                if (readings_due.size() == 0)
                    report("beat with nothing outstanding", m_tdata[15:0], '0);
                else
                begin
                    want = readings_due.pop_front();
                    check_field("window_done", m_tuser[0], want.win_done);
                    check_field("median_adc", m_tdata[11:0], want.median);
                    check_field("sensor_mv", m_tdata[27:12], want.sensor_mv);
                    check_field("temperature_x100", m_tdata[43:28], want.temp_x100);
                    check_field("temp_valid", m_tuser[1], want.temp_ok);
                    check_field("supply_done", m_tuser[2], want.sup_done);
                    check_field("supply_mv", m_tdata[59:44], want.supply_mv);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = condition_sample(s_tdata[11:0], s_tdata[23:12], s_tuser);
                windows  += want.win_done;
                rejected += (want.win_done && !want.temp_ok);
                averages += want.sup_done;
                readings_due.push_back(want);
            end
            pending <= readings_due.size();
        end
    end

endmodule

// ===== test/tb_median_temp_sensor_conditioner.sv =====
module tb_median_temp_sensor_conditioner;
    timeunit 1ns;
    timeprecision 1ps;

    import mtsc_pkg::*;

    localparam int CYCLE_LIMIT = 150000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [10:0] RX_CYCLE = 11'b10110111001;
    localparam logic [11:0] EDGE_TEMPS [16] = '{
        12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'h800, 12'h7FF, 12'h001, 12'hFFE,
        12'h064, 12'h064, 12'h064, 12'hBB8, 12'hFFF, 12'h000, 12'h005, 12'hFFF
    };

    typedef enum int {RX_ALWAYS, RX_COIN, RX_CYCLIC} rx_style_t;
    typedef enum int {T_SPREAD, T_CLUSTER, T_RAILS, T_REPEAT} temp_mix_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;  // temp_sample, supply_sample
    logic                   s_tuser   = 1'b0; // restart_supply
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [63:0]            m_tdata;  // median_adc, sensor_mv, temperature_x100, supply_mv
    logic [2:0]             m_tuser;  // window_done, temp_valid, supply_done
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int pending;
    int errors;
    int windows;
    int rejected;
    int averages;

    rx_style_t rx_style   = RX_ALWAYS;
    bit        want_hold  = 1'b0;
    bit        hold_taken = 1'b0;
    int        rx_phase   = 0;
    int        cycles     = 0;

    bit tx_gaps       = 1'b0;
    int burst_left    = 0;
    int items_sent    = 0;
    int settings      = 1;
    int supply_fed    = 0;
    int restart_delay = 0;

    median_temp_sensor_conditioner dut (.*);

    mtsc_reading_check conditioner_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: one long hold-off on request, otherwise its own stall pattern
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (want_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rx_phase++;
                case (rx_style)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= ($urandom_range(0, 99) < 65);
                    default:   m_tready <= RX_CYCLE[rx_phase % 11];
                endcase
            end
        end
    end

    task automatic send_item(input logic [11:0] ts, input logic [11:0] ss, input logic rs);
        s_tvalid <= 1'b1;
        s_tdata  <= {ss, ts};
        s_tuser  <= rs;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (tx_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // unused upper bits of narrow registers carry junk on purpose
    task automatic set_config(input int slope, input int offset, input int lo, input int hi,
                              input int unsigned vscale, input int unsigned sscale);
        write_reg(REG_CAL_SLOPE, 24'(slope));
        write_reg(REG_CAL_OFFSET, 24'(offset));
        write_reg(REG_TEMP_LOW, {8'($urandom), 16'(lo)});
        write_reg(REG_TEMP_HIGH, {8'($urandom), 16'(hi)});
        write_reg(REG_VOLT_SCALE, {4'($urandom), 20'(vscale)});
        write_reg(REG_SUPPLY_SCALE, {4'($urandom), 20'(sscale)});
        // spare index, must not land anywhere
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 24'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    task automatic random_config(input bit wild);
        int lo;
        lo = $urandom_range(0, 20000) - 10000;
        if (wild)
            set_config($signed(24'($urandom)), $signed(24'($urandom)),
                       $signed(16'($urandom)), $signed(16'($urandom)),
                       $urandom_range(0, 1048575), $urandom_range(0, 1048575));
        else
            set_config($urandom_range(0, 1600000) - 800000, $urandom_range(0, 60000) - 30000,
                       lo, lo + $urandom_range(0, 20000) - 2000,
                       $urandom_range(20000, 80000), $urandom_range(100000, 400000));
    endtask

    // mostly complete supply averages with a restart shortly after each,
    // plus stray restarts that cut an average short
    task automatic run_random(input int count);
        int k;
        int v;
        int center;
        int sup_level;
        temp_mix_t mix;
        logic [11:0] ts;
        logic [11:0] ss;
        logic rs;
        mix = T_SPREAD;
        center = 0;
        sup_level = -1;
        for (k = 0; k < count; k++)
        begin
            if (k % WINDOW_DEF == 0)
            begin
                mix = temp_mix_t'($urandom_range(0, 3));
                center = $urandom_range(0, 4095);
                sup_level = $urandom_range(0, 1) ? int'($urandom_range(0, 4095)) : -1;
            end
            case (mix)
                T_SPREAD:  v = $urandom_range(0, 4095);
                T_CLUSTER: v = center + int'($urandom_range(0, 40)) - 20;
                T_RAILS:   v = ($urandom_range(0, 3) == 0) ? center
                                : ($urandom_range(0, 1) ? 4095 : 0);
                default:   v = center ^ int'($urandom_range(0, 3));
            endcase
            ts = (v < 0) ? 12'd0 : (v > 4095) ? 12'hFFF : 12'(v);
            ss = (sup_level < 0) ? 12'($urandom) : 12'(sup_level ^ int'($urandom_range(0, 7)));
            rs = (supply_fed >= SUPPLY_SAMPLES_DEF + restart_delay)
                 || ($urandom_range(0, 99) < 3);
            if (rs)
            begin
                supply_fed = 0;
                restart_delay = $urandom_range(0, 6);
            end
            supply_fed++;
            send_item(ts, ss, rs);
        end
    endtask

    initial
    begin : stimulus
        int k;
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, back-to-back beats, rail samples
        for (k = 0; k < 16; k++)
            send_item(EDGE_TEMPS[k], k[0] ? 12'h000 : 12'hFFF, k == 0);
        // restart in the middle of an average
        for (k = 0; k < 6; k++)
            send_item(12'hA5A ^ 12'(k), 12'hFFF, k == 3);
        supply_fed = 3;
        drain();

        rx_style <= RX_COIN;
        tx_gaps = 1'b1;
        set_config(65536, -2000, -1000, 1500, 52800, 286059);
        run_random(110);

        drain();
        rx_style <= RX_CYCLIC;
        // fractional slope with negative readings
        set_config(-15014, 300, -500, 250, 33333, 70000);
        run_random(110);

        drain();
        rx_style <= RX_COIN;
        set_config(8388607, -8388608, -32768, 32767, 1048575, 1048575);
        run_random(100);

        drain();
        // inverted bounds, zero scales
        set_config(-8388608, 8388607, 100, -100, 0, 0);
        run_random(100);

        // output held off while input keeps coming
        drain();
        random_config(1'b0);
        tx_gaps = 1'b0;
        want_hold <= 1'b1;
        run_random(60);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            random_config(phase[0]);
            rx_style <= rx_style_t'($urandom_range(0, 2));
            tx_gaps = ($urandom_range(0, 3) != 0);
            run_random(110);
            drain();
        end

        repeat (12) @(posedge clk);
        $display("covered %0d input beats over %0d register settings, bursty and stalled",
                 items_sent, settings);
        $display("%0d median windows (%0d out of bounds), %0d supply averages",
                 windows, rejected, averages);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== median_temp_sensor_conditioner.f =====
rtl/mtsc_pkg.sv
rtl/mtsc_cell.sv
rtl/mtsc_sort_row.sv
rtl/mtsc_supply.sv
rtl/median_temp_sensor_conditioner.sv
test/mtsc_reading_check.sv
test/tb_median_temp_sensor_conditioner.sv
